>>> src/vhsp_pkg.sv
// Shared constants and types for the vector Helmholtz split power block.
// Used by vhsp_sine and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package vhsp_pkg;

  // Largest lattice size and resolution of the quarter-wave phase.
  localparam int MAX_GRID        = 1024;
  localparam int SINE_TABLE_BITS = 10;

  // Grid index after the x offset add, and clamped lattice size.
  localparam int IDX_W  = 11;
  localparam int LEN_W  = $clog2(MAX_GRID) + 1;
  localparam int SINE_W = 16;

  // Restoring divider steps packed into each register stage.
  localparam int STEPS_PER_STAGE = 4;
  localparam int MOD_STEPS       = IDX_W;
  localparam int MOD_STAGES      = (MOD_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Phase quotient q in [0, 2^B] and its divider.
  localparam int Q_W         = SINE_TABLE_BITS + 1;
  localparam int NUM_W       = LEN_W + SINE_TABLE_BITS + 2;
  localparam int DEN_W       = LEN_W + 1;
  localparam int QDIV_STAGES = (Q_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Polynomial: one stage for u^2, five Horner steps, final multiply, rounding.
  localparam int HORNER_STEPS = 5;
  localparam int SINE_LAT     = MOD_STAGES + 1 + QDIV_STAGES + 1 + HORNER_STEPS + 2;

  typedef logic signed [SINE_W-1:0] sine_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_OFFSET = 2'd0;
  localparam logic [1:0] REG_SIZE_X   = 2'd1;
  localparam logic [1:0] REG_SIZE_Y   = 2'd2;
  localparam logic [1:0] REG_SIZE_Z   = 2'd3;

endpackage

>>> src/vhsp_sine.sv
// One lattice momentum lane: wraps a grid index and returns sin(pi*n/L) in Q1.15.
// Depends on vhsp_pkg; fully pipelined, one item per cycle.
`timescale 1ns / 1ps

module vhsp_sine (
  input  logic                          clk,
  input  logic [vhsp_pkg::IDX_W-1:0]    idx,
  input  logic [vhsp_pkg::LEN_W-1:0]    len,
  output vhsp_pkg::sine_t               sine
);

  localparam int IDX_W  = vhsp_pkg::IDX_W;
  localparam int LEN_W  = vhsp_pkg::LEN_W;
  localparam int Q_W    = vhsp_pkg::Q_W;
  localparam int NUM_W  = vhsp_pkg::NUM_W;
  localparam int DEN_W  = vhsp_pkg::DEN_W;
  localparam int B      = vhsp_pkg::SINE_TABLE_BITS;
  localparam int SPS    = vhsp_pkg::STEPS_PER_STAGE;
  localparam int MOD_ST = vhsp_pkg::MOD_STAGES;
  localparam int QD_ST  = vhsp_pkg::QDIV_STAGES;
  localparam int HS     = vhsp_pkg::HORNER_STEPS;

  // Odd sine polynomial coefficients in u = angle / (pi/2), Q2.30.
  localparam logic signed [32:0] COEF [6] = '{
    33'sd1686629713, -33'sd693598668, 33'sd85569306,
    -33'sd5026995, 33'sd172272, -33'sd3864
  };

  // Q30 product rounded to nearest, halves away from zero.
  function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [33:0] m;
    logic signed [32:0] r;
    ma = a[32] ? 32'(-a) : a[31:0];
    mb = b[32] ? 32'(-b) : b[31:0];
    p  = ma * mb;
    m  = 34'((p + 64'h2000_0000) >> 30);
    r  = signed'(m[32:0]);
    return (a[32] ^ b[32]) ? -r : r;
  endfunction

  // Index modulo lattice size, a few restoring steps per stage.
  logic [IDX_W-1:0] m_idx [1:MOD_ST];
  logic [LEN_W-1:0] m_rem [1:MOD_ST];
  logic [LEN_W-1:0] m_len [1:MOD_ST];

  for (genvar g = 0; g < MOD_ST; g++) begin : g_mod
    logic [IDX_W-1:0] src_idx;
    logic [LEN_W-1:0] src_rem;
    logic [LEN_W-1:0] src_len;
    logic [IDX_W-1:0] idx_c;
    logic [LEN_W-1:0] rem_c;

    if (g == 0) begin : g_first
      assign src_idx = idx;
      assign src_rem = '0;
      assign src_len = len;
    end else begin : g_rest
      assign src_idx = m_idx[g];
      assign src_rem = m_rem[g];
      assign src_len = m_len[g];
    end

    always_comb begin
      logic [LEN_W:0] t;
      t     = '0;
      idx_c = src_idx;
      rem_c = src_rem;
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < vhsp_pkg::MOD_STEPS) begin
          t = {rem_c, idx_c[IDX_W-1]};
          if (t >= {1'b0, src_len}) begin
            t = t - {1'b0, src_len};
          end
          rem_c = t[LEN_W-1:0];
          idx_c = idx_c << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      m_idx[g+1] <= idx_c;
      m_rem[g+1] <= rem_c;
      m_len[g+1] <= src_len;
    end
  end

  // Fold to |n| <= L/2 and form the phase dividend and divisor.
  logic [NUM_W-1:0] w_num;
  logic [DEN_W-1:0] w_den;
  logic             w_neg;

  always_ff @(posedge clk) begin
    logic [LEN_W-1:0] a;
    logic             neg;
    if (m_rem[MOD_ST] > (m_len[MOD_ST] >> 1)) begin
      a   = m_len[MOD_ST] - m_rem[MOD_ST];
      neg = 1'b1;
    end else begin
      a   = m_rem[MOD_ST];
      neg = 1'b0;
    end
    w_num <= (NUM_W'(a) << (B + 2)) + NUM_W'(m_len[MOD_ST]);
    w_den <= {m_len[MOD_ST], 1'b0};
    w_neg <= neg;
  end

  // Phase quotient q = floor(num / (2L)).
  logic [Q_W-1:0]   d_low [1:QD_ST];
  logic [DEN_W-1:0] d_rem [1:QD_ST];
  logic [Q_W-1:0]   d_q   [1:QD_ST];
  logic [DEN_W-1:0] d_den [1:QD_ST];
  logic             d_neg [1:QD_ST];

  for (genvar g = 0; g < QD_ST; g++) begin : g_qdiv
    logic [Q_W-1:0]   src_low;
    logic [DEN_W-1:0] src_rem;
    logic [Q_W-1:0]   src_q;
    logic [DEN_W-1:0] src_den;
    logic             src_neg;
    logic [Q_W-1:0]   low_c;
    logic [DEN_W-1:0] rem_c;
    logic [Q_W-1:0]   q_c;

    if (g == 0) begin : g_first
      assign src_low = w_num[Q_W-1:0];
      assign src_rem = w_num[NUM_W-1:Q_W];
      assign src_q   = '0;
      assign src_den = w_den;
      assign src_neg = w_neg;
    end else begin : g_rest
      assign src_low = d_low[g];
      assign src_rem = d_rem[g];
      assign src_q   = d_q[g];
      assign src_den = d_den[g];
      assign src_neg = d_neg[g];
    end

    always_comb begin
      logic [DEN_W:0] t;
      logic           qb;
      t     = '0;
      qb    = 1'b0;
      low_c = src_low;
      rem_c = src_rem;
      q_c   = src_q;
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < Q_W) begin
          t  = {rem_c, low_c[Q_W-1]};
          qb = (t >= {1'b0, src_den});
          if (qb) begin
            t = t - {1'b0, src_den};
          end
          rem_c = t[DEN_W-1:0];
          q_c   = {q_c[Q_W-2:0], qb};
          low_c = low_c << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      d_low[g+1] <= low_c;
      d_rem[g+1] <= rem_c;
      d_q[g+1]   <= q_c;
      d_den[g+1] <= src_den;
      d_neg[g+1] <= src_neg;
    end
  end

  // u = q scaled to Q2.30 and its square.
  logic signed [32:0] p_u;
  logic signed [32:0] p_u2;
  logic               p_neg;

  always_ff @(posedge clk) begin
    logic [31:0]        uu;
    logic signed [32:0] u;
    uu    = 32'(d_q[QD_ST]) << (30 - B);
    u     = signed'({1'b0, uu});
    p_u   <= u;
    p_u2  <= mul_q30(u, u);
    p_neg <= d_neg[QD_ST];
  end

  // Horner steps of the polynomial in u^2, one multiply per stage.
  logic signed [32:0] h_acc [1:HS];
  logic signed [32:0] h_u   [1:HS];
  logic signed [32:0] h_u2  [1:HS];
  logic               h_neg [1:HS];

  for (genvar k = 0; k < HS; k++) begin : g_horner
    logic signed [32:0] src_acc;
    logic signed [32:0] src_u;
    logic signed [32:0] src_u2;
    logic               src_neg;

    if (k == 0) begin : g_first
      assign src_acc = COEF[HS];
      assign src_u   = p_u;
      assign src_u2  = p_u2;
      assign src_neg = p_neg;
    end else begin : g_rest
      assign src_acc = h_acc[k];
      assign src_u   = h_u[k];
      assign src_u2  = h_u2[k];
      assign src_neg = h_neg[k];
    end

    always_ff @(posedge clk) begin
      h_acc[k+1] <= COEF[HS-1-k] + mul_q30(src_acc, src_u2);
      h_u[k+1]   <= src_u;
      h_u2[k+1]  <= src_u2;
      h_neg[k+1] <= src_neg;
    end
  end

  // Final odd factor u.
  logic signed [32:0] r_val;
  logic               r_neg;

  always_ff @(posedge clk) begin
    r_val <= mul_q30(h_acc[HS], h_u[HS]);
    r_neg <= h_neg[HS];
  end

  // Round Q30 to Q1.15, saturate and apply the sign of n.
  always_ff @(posedge clk) begin
    logic [32:0] tt;
    logic [17:0] mag;
    logic [14:0] s;
    tt  = {1'b0, r_val[31:0]} + 33'h4000;
    mag = tt[32:15];
    if (r_val <= 0) begin
      s = '0;
    end else if (mag > 18'd32767) begin
      s = 15'h7FFF;
    end else begin
      s = mag[14:0];
    end
    sine <= r_neg ? -signed'({1'b0, s}) : signed'({1'b0, s});
  end

endmodule

>>> src/vector_helmholtz_split_power_core.sv
// Top level of the vector Helmholtz split: transverse, longitudinal and total power.
// Depends on vhsp_pkg and vhsp_sine (three lattice momentum lanes).
//
//  channel   handshake          payload
//  config    cfg_we             cfg_index, cfg_data
//  input     start, busy        plane_x, row_y, col_z, v1..v3 re/im
//  result    done               power_transverse, power_longitudinal, power_total
//
// One item is accepted per cycle; busy stays low. Each result passes from its item
// through one capture stage, 15 for the sine lanes (index modulo, phase division,
// polynomial), 5 for products and |k.v|^2, 13 for the 50-bit restoring division
// by |k|^2 and one output stage. Reset clears the valid pipeline, zeroes the x
// offset and sets the three sizes to 256; the receiver cannot stall.
`timescale 1ns / 1ps

module vector_helmholtz_split_power_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic [9:0]         plane_x,
  input  logic [9:0]         row_y,
  input  logic [9:0]         col_z,
  input  logic signed [23:0] v1_re,
  input  logic signed [23:0] v1_im,
  input  logic signed [23:0] v2_re,
  input  logic signed [23:0] v2_im,
  input  logic signed [23:0] v3_re,
  input  logic signed [23:0] v3_im,
  output logic               done,
  output logic [47:0]        power_transverse,
  output logic [47:0]        power_longitudinal,
  output logic [47:0]        power_total
);

  localparam int LEN_W     = vhsp_pkg::LEN_W;
  localparam int IDX_W     = vhsp_pkg::IDX_W;
  localparam int SLAT      = vhsp_pkg::SINE_LAT;
  localparam int DIV_BITS  = 50;
  localparam int DIV_SPS   = vhsp_pkg::STEPS_PER_STAGE;
  localparam int DIV_ST    = (DIV_BITS + DIV_SPS - 1) / DIV_SPS;
  localparam int LAT       = 1 + SLAT + 5 + DIV_ST + 1;

  assign busy = 1'b0;

  // Configuration registers.
  logic [9:0]  x_offset;
  logic [10:0] size_x;
  logic [10:0] size_y;
  logic [10:0] size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      size_x   <= 11'd256;
      size_y   <= 11'd256;
      size_z   <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vhsp_pkg::REG_X_OFFSET: x_offset <= cfg_data[9:0];
        vhsp_pkg::REG_SIZE_X:   size_x   <= cfg_data;
        vhsp_pkg::REG_SIZE_Y:   size_y   <= cfg_data;
        vhsp_pkg::REG_SIZE_Z:   size_z   <= cfg_data;
      endcase
    end
  end

  function automatic logic [LEN_W-1:0] clamp_size(input logic [10:0] s);
    if (s < 11'd2) begin
      return LEN_W'(2);
    end else if (32'(s) > vhsp_pkg::MAX_GRID) begin
      return LEN_W'(vhsp_pkg::MAX_GRID);
    end
    return LEN_W'(s);
  endfunction

  // Capture stage: global x index and clamped sizes.
  logic               s0_valid;
  logic [IDX_W-1:0]   s0_idx_x;
  logic [IDX_W-1:0]   s0_idx_y;
  logic [IDX_W-1:0]   s0_idx_z;
  logic [LEN_W-1:0]   s0_len_x;
  logic [LEN_W-1:0]   s0_len_y;
  logic [LEN_W-1:0]   s0_len_z;
  logic signed [23:0] s0_v [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_x <= IDX_W'(plane_x) + IDX_W'(x_offset);
    s0_idx_y <= IDX_W'(row_y);
    s0_idx_z <= IDX_W'(col_z);
    s0_len_x <= clamp_size(size_x);
    s0_len_y <= clamp_size(size_y);
    s0_len_z <= clamp_size(size_z);
    s0_v[0]  <= v1_re;
    s0_v[1]  <= v1_im;
    s0_v[2]  <= v2_re;
    s0_v[3]  <= v2_im;
    s0_v[4]  <= v3_re;
    s0_v[5]  <= v3_im;
  end

  // Lattice momentum lanes.
  vhsp_pkg::sine_t sine [3];

  vhsp_sine u_sine_x (.clk(clk), .idx(s0_idx_x), .len(s0_len_x), .sine(sine[0]));
  vhsp_sine u_sine_y (.clk(clk), .idx(s0_idx_y), .len(s0_len_y), .sine(sine[1]));
  vhsp_sine u_sine_z (.clk(clk), .idx(s0_idx_z), .len(s0_len_z), .sine(sine[2]));

  // Vector components and valid bits wait alongside the lanes.
  logic [SLAT-1:0]    ln_valid;
  logic signed [23:0] ln_v [SLAT][6];

  always_ff @(posedge clk) begin
    if (rst) begin
      ln_valid <= '0;
    end else begin
      ln_valid <= {ln_valid[SLAT-2:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    ln_v[0] <= s0_v;
    for (int k = 1; k < SLAT; k++) begin
      ln_v[k] <= ln_v[k-1];
    end
  end

  // Products s*v, squares of v and of s.
  logic               a_valid;
  logic signed [39:0] a_pre [3];
  logic signed [39:0] a_pim [3];
  logic [46:0]        a_sq  [6];
  logic [29:0]        a_ss  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= ln_valid[SLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [47:0] vsq;
    logic signed [31:0] ssq;
    for (int i = 0; i < 3; i++) begin
      a_pre[i] <= sine[i] * ln_v[SLAT-1][2*i];
      a_pim[i] <= sine[i] * ln_v[SLAT-1][2*i+1];
      ssq      = sine[i] * sine[i];
      a_ss[i]  <= ssq[29:0];
    end
    for (int i = 0; i < 6; i++) begin
      vsq     = ln_v[SLAT-1][i] * ln_v[SLAT-1][i];
      a_sq[i] <= vsq[46:0];
    end
  end

  // Dot products, total power and |s|^2.
  logic               b_valid;
  logic signed [41:0] b_dre;
  logic signed [41:0] b_dim;
  logic [48:0]        b_total;
  logic [31:0]        b_k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_dre   <= 42'(a_pre[0]) + 42'(a_pre[1]) + 42'(a_pre[2]);
    b_dim   <= 42'(a_pim[0]) + 42'(a_pim[1]) + 42'(a_pim[2]);
    b_total <= 49'(a_sq[0]) + 49'(a_sq[1]) + 49'(a_sq[2])
             + 49'(a_sq[3]) + 49'(a_sq[4]) + 49'(a_sq[5]);
    b_k2    <= 32'(a_ss[0]) + 32'(a_ss[1]) + 32'(a_ss[2]);
  end

  // Magnitudes and 20x20 partial products of the squares.
  logic        c_valid;
  logic [39:0] c_hh [2];
  logic [39:0] c_hl [2];
  logic [39:0] c_ll [2];
  logic [48:0] c_total;
  logic [31:0] c_k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [39:0] m [2];
    m[0] = b_dre[41] ? 40'(-b_dre) : b_dre[39:0];
    m[1] = b_dim[41] ? 40'(-b_dim) : b_dim[39:0];
    for (int i = 0; i < 2; i++) begin
      c_hh[i] <= m[i][39:20] * m[i][39:20];
      c_hl[i] <= m[i][39:20] * m[i][19:0];
      c_ll[i] <= m[i][19:0] * m[i][19:0];
    end
    c_total <= b_total;
    c_k2    <= b_k2;
  end

  // Squares of the real and imaginary dot products.
  logic        e_valid;
  logic [79:0] e_sq [2];
  logic [48:0] e_total;
  logic [31:0] e_k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      e_sq[i] <= (80'(c_hh[i]) << 40) + (80'(c_hl[i]) << 21) + 80'(c_ll[i]);
    end
    e_total <= c_total;
    e_k2    <= c_k2;
  end

  // |s.v|^2 as one 81-bit dividend.
  logic        f_valid;
  logic [80:0] f_n;
  logic [48:0] f_total;
  logic [31:0] f_k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_n     <= 81'(e_sq[0]) + 81'(e_sq[1]);
    f_total <= e_total;
    f_k2    <= e_k2;
  end

  // Restoring division of |s.v|^2 by |s|^2; a quotient of 2^50 or more
  // exceeds any total and is flagged instead of computed.
  logic                dv_valid [1:DIV_ST];
  logic [DIV_BITS-1:0] dv_low   [1:DIV_ST];
  logic [31:0]         dv_rem   [1:DIV_ST];
  logic [DIV_BITS-1:0] dv_q     [1:DIV_ST];
  logic [31:0]         dv_k2    [1:DIV_ST];
  logic [48:0]         dv_total [1:DIV_ST];
  logic                dv_zero  [1:DIV_ST];
  logic                dv_ovf   [1:DIV_ST];

  for (genvar g = 0; g < DIV_ST; g++) begin : g_div
    logic                src_valid;
    logic [DIV_BITS-1:0] src_low;
    logic [31:0]         src_rem;
    logic [DIV_BITS-1:0] src_q;
    logic [31:0]         src_k2;
    logic [48:0]         src_total;
    logic                src_zero;
    logic                src_ovf;
    logic [DIV_BITS-1:0] low_c;
    logic [31:0]         rem_c;
    logic [DIV_BITS-1:0] q_c;

    if (g == 0) begin : g_first
      assign src_valid = f_valid;
      assign src_low   = f_n[DIV_BITS-1:0];
      assign src_rem   = 32'(f_n[80:DIV_BITS]);
      assign src_q     = '0;
      assign src_k2    = f_k2;
      assign src_total = f_total;
      assign src_zero  = (f_k2 == '0);
      assign src_ovf   = (32'(f_n[80:DIV_BITS]) >= f_k2);
    end else begin : g_rest
      assign src_valid = dv_valid[g];
      assign src_low   = dv_low[g];
      assign src_rem   = dv_rem[g];
      assign src_q     = dv_q[g];
      assign src_k2    = dv_k2[g];
      assign src_total = dv_total[g];
      assign src_zero  = dv_zero[g];
      assign src_ovf   = dv_ovf[g];
    end

    always_comb begin
      logic [32:0] t;
      logic        qb;
      t     = '0;
      qb    = 1'b0;
      low_c = src_low;
      rem_c = src_rem;
      q_c   = src_q;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (g * DIV_SPS + j < DIV_BITS) begin
          t  = {rem_c, low_c[DIV_BITS-1]};
          qb = (t >= {1'b0, src_k2});
          if (qb) begin
            t = t - {1'b0, src_k2};
          end
          rem_c = t[31:0];
          q_c   = {q_c[DIV_BITS-2:0], qb};
          low_c = low_c << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else begin
        dv_valid[g+1] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      dv_low[g+1]   <= low_c;
      dv_rem[g+1]   <= rem_c;
      dv_q[g+1]     <= q_c;
      dv_k2[g+1]    <= src_k2;
      dv_total[g+1] <= src_total;
      dv_zero[g+1]  <= src_zero;
      dv_ovf[g+1]   <= src_ovf;
    end
  end

  // Output stage: clamp longitudinal to total, subtract, saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[DIV_ST];
    end
  end

  always_ff @(posedge clk) begin
    logic [48:0] tot;
    logic [48:0] lng;
    logic [48:0] trn;
    tot = dv_total[DIV_ST];
    if (dv_zero[DIV_ST] || dv_ovf[DIV_ST] || (dv_q[DIV_ST] > DIV_BITS'(tot))) begin
      lng = tot;
    end else begin
      lng = dv_q[DIV_ST][48:0];
    end
    trn = tot - lng;
    power_total        <= tot[48] ? '1 : tot[47:0];
    power_longitudinal <= lng[48] ? '1 : lng[47:0];
    power_transverse   <= trn[48] ? '1 : trn[47:0];
  end

`ifndef NO_ASSERTIONS
  // A result only follows a matching accepted item.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching accepted item");

  // The split never exceeds the total.
  a_long_le_total: assert property (@(posedge clk) disable iff (rst)
    done |-> power_longitudinal <= power_total)
    else $error("longitudinal power above total");

  // Without saturation the two parts add up to the total.
  a_parts_sum: assert property (@(posedge clk) disable iff (rst)
    (done && power_total != 48'hFFFF_FFFF_FFFF) |->
      (49'(power_transverse) + 49'(power_longitudinal) == 49'(power_total)))
    else $error("transverse plus longitudinal differs from total");

  // The zero mode has no transverse power.
  a_zero_mode: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[DIV_ST] && dv_zero[DIV_ST]) |=> (done && power_transverse == '0))
    else $error("zero mode with transverse power");
`endif

endmodule

>>> tb/tb_vector_helmholtz_split_power_core.sv
// Self-checking testbench for vector_helmholtz_split_power_core.
// Predicts the three mode powers in SystemVerilog and compares them in order;
// depends on vhsp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_vector_helmholtz_split_power_core;

  localparam int        DRAIN_CYCLES = 60;
  localparam logic [47:0] POWER_MAX  = 48'hFFFF_FFFF_FFFF;

  // Odd sine polynomial coefficients, Q2.30.
  localparam longint SIN_C0 = 1686629713;
  localparam longint SIN_C1 = -693598668;
  localparam longint SIN_C2 = 85569306;
  localparam longint SIN_C3 = -5026995;
  localparam longint SIN_C4 = 172272;
  localparam longint SIN_C5 = -3864;

  typedef struct {
    logic [9:0]         px, ry, cz;
    logic signed [23:0] vr [3];
    logic signed [23:0] vi [3];
  } mode_t;

  typedef struct packed {
    logic [47:0] trn, lng, tot;
  } powers_t;

  logic clk, rst, start, busy, cfg_we, done;
  logic [1:0] cfg_index;
  logic [10:0] cfg_data;
  logic [9:0] plane_x, row_y, col_z;
  logic signed [23:0] v1_re, v1_im, v2_re, v2_im, v3_re, v3_im;
  logic [47:0] power_transverse, power_longitudinal, power_total;

  // Shadow copy of the configuration registers.
  logic [9:0]  cur_x_offset;
  logic [10:0] cur_size_x, cur_size_y, cur_size_z;

  powers_t pending_powers[$];
  int mismatches;

  vector_helmholtz_split_power_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .plane_x(plane_x), .row_y(row_y), .col_z(col_z),
    .v1_re(v1_re), .v1_im(v1_im), .v2_re(v2_re), .v2_im(v2_im),
    .v3_re(v3_re), .v3_im(v3_im),
    .done(done), .power_transverse(power_transverse),
    .power_longitudinal(power_longitudinal), .power_total(power_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Q30 product rounded to nearest, halves away from zero.
  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + 64'h2000_0000) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic int unsigned size_clamp(logic [10:0] s);
    if (s < 2) return 2;
    if (s > vhsp_pkg::MAX_GRID) return vhsp_pkg::MAX_GRID;
    return s;
  endfunction

  // Signed Q1.15 lattice momentum for one axis.
  function automatic int lattice_momentum(int unsigned idx, int unsigned len);
    int unsigned n, q;
    bit neg;
    longint u, u2, acc, r;
    int s;
    longint unsigned t;
    n = idx % len;
    neg = 1'b0;
    if (n > len / 2) begin
      n = len - n;
      neg = 1'b1;
    end
    q = ((n << (vhsp_pkg::SINE_TABLE_BITS + 2)) + len) / (2 * len);
    u = longint'(q) << (30 - vhsp_pkg::SINE_TABLE_BITS);
    u2 = q30_mul(u, u);
    acc = SIN_C5;
    acc = SIN_C4 + q30_mul(acc, u2);
    acc = SIN_C3 + q30_mul(acc, u2);
    acc = SIN_C2 + q30_mul(acc, u2);
    acc = SIN_C1 + q30_mul(acc, u2);
    acc = SIN_C0 + q30_mul(acc, u2);
    r = q30_mul(acc, u);
    if (r <= 0) s = 0;
    else begin
      t = (longint'(r) + 64'h4000) >> 15;
      s = (t > 32767) ? 32767 : int'(t);
    end
    return neg ? -s : s;
  endfunction

  // Total, longitudinal and transverse power of one mode.
  function automatic powers_t split_power(mode_t m);
    int s[3];
    logic signed [63:0] d_re, d_im;
    logic [63:0] mr, mi;
    logic [127:0] num, quo;
    logic [63:0] total, k2, lng, trn;
    powers_t p;
    s[0] = lattice_momentum(int'(m.px) + int'(cur_x_offset), size_clamp(cur_size_x));
    s[1] = lattice_momentum(m.ry, size_clamp(cur_size_y));
    s[2] = lattice_momentum(m.cz, size_clamp(cur_size_z));
    d_re = 0; d_im = 0; total = 0; k2 = 0;
    for (int i = 0; i < 3; i++) begin
      total += 64'(longint'(m.vr[i]) * longint'(m.vr[i]));
      total += 64'(longint'(m.vi[i]) * longint'(m.vi[i]));
      k2 += 64'(longint'(s[i]) * longint'(s[i]));
      d_re += longint'(s[i]) * longint'(m.vr[i]);
      d_im += longint'(s[i]) * longint'(m.vi[i]);
    end
    if (k2 == 0) lng = total;
    else begin
      mr = d_re[63] ? -d_re : d_re;
      mi = d_im[63] ? -d_im : d_im;
      num = 128'(mr) * 128'(mr) + 128'(mi) * 128'(mi);
      quo = num / 128'(k2);
      lng = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
      if (lng > total) lng = total;
    end
    trn = total - lng;
    p.trn = (trn > 64'(POWER_MAX)) ? POWER_MAX : trn[47:0];
    p.lng = (lng > 64'(POWER_MAX)) ? POWER_MAX : lng[47:0];
    p.tot = (total > 64'(POWER_MAX)) ? POWER_MAX : total[47:0];
    return p;
  endfunction

  // Result checker: every strobe pops the oldest expectation, if there is one.
  always @(posedge clk) begin
    powers_t e;
    if (!rst && done) begin
      if (pending_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
      end else begin
        e = pending_powers.pop_front();
        if (e.trn !== power_transverse || e.lng !== power_longitudinal ||
            e.tot !== power_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: exp T=%h L=%h P=%h got T=%h L=%h P=%h",
                     $realtime, e.trn, e.lng, e.tot, power_transverse,
                     power_longitudinal, power_total);
        end
      end
    end
  end

  // One register write; the write enable then idles before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vhsp_pkg::REG_X_OFFSET: cur_x_offset = val[9:0];
      vhsp_pkg::REG_SIZE_X:   cur_size_x = val;
      vhsp_pkg::REG_SIZE_Y:   cur_size_y = val;
      default:                cur_size_z = val;
    endcase
    @(negedge clk);
  endtask

  // Wait for every expected result, then a margin for the pipeline.
  task automatic drain();
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drive one item; the expectation is queued with the predicted powers.
  task automatic send_mode(mode_t m, bit hold_high);
    start <= 1'b1;
    plane_x <= m.px; row_y <= m.ry; col_z <= m.cz;
    v1_re <= m.vr[0]; v1_im <= m.vi[0];
    v2_re <= m.vr[1]; v2_im <= m.vi[1];
    v3_re <= m.vr[2]; v3_im <= m.vi[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_powers.push_back(split_power(m));
    @(negedge clk);
    if (!hold_high) start <= 1'b0;
  endtask

  function automatic mode_t random_mode();
    mode_t m;
    m.px = 10'($urandom); m.ry = 10'($urandom); m.cz = 10'($urandom);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0: begin m.vr[i] = 24'($urandom); m.vi[i] = 24'($urandom); end
        1: begin m.vr[i] = 24'($urandom_range(0, 511) - 256);
                 m.vi[i] = 24'($urandom_range(0, 511) - 256); end
        2: begin m.vr[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                 m.vi[i] = 24'($urandom); end
        default: begin m.vr[i] = 24'($signed($urandom_range(0, 131071)) - 65536);
                       m.vi[i] = '0; end
      endcase
    end
    return m;
  endfunction

  // Random idle gap before an item: mostly none or short, a few long.
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    start <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  // Random phase with a given setting.
  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      idle_gap();
      send_mode(random_mode(), 1'b1);
    end
    start <= 1'b0;
  endtask

  // Directed rows: indices and components; expected powers where obvious.
  typedef struct {
    mode_t m;
    bit known;
    powers_t p;
  } row_t;

  row_t rows[$];

  function automatic row_t mk_row(logic [9:0] px, logic [9:0] ry, logic [9:0] cz,
                                  logic signed [23:0] a, logic signed [23:0] b,
                                  bit known, logic [47:0] t, logic [47:0] l,
                                  logic [47:0] p);
    row_t r;
    r.m.px = px; r.m.ry = ry; r.m.cz = cz;
    for (int i = 0; i < 3; i++) begin
      r.m.vr[i] = a; r.m.vi[i] = b;
    end
    r.known = known;
    r.p.trn = t; r.p.lng = l; r.p.tot = p;
    return r;
  endfunction

  initial begin
    powers_t got;
    mismatches = 0;
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = vhsp_pkg::REG_X_OFFSET;
    cfg_data = '0;
    plane_x = '0; row_y = '0; col_z = '0;
    v1_re = '0; v1_im = '0; v2_re = '0; v2_im = '0; v3_re = '0; v3_im = '0;
    cur_x_offset = 0; cur_size_x = 256; cur_size_y = 256; cur_size_z = 256;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero mode with known powers, saturating extremes, and mixed modes.
    rows.push_back(mk_row(0, 0, 0, 24'h010000, 0, 1, 0, 48'd3 << 32, 48'd3 << 32));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, 24'h800000, 24'h800000, 1, 0, POWER_MAX, POWER_MAX));
    rows.push_back(mk_row(1023, 1023, 1023, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0));
    rows.push_back(mk_row(128, 128, 128, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0));
    rows.push_back(mk_row(64, 0, 0, 24'h012345, -24'sd77, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 200, 0, -24'sd1, 24'sd1, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 129, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0));
    rows.push_back(mk_row(300, 700, 511, 24'h00ABCD, 24'hFF5432, 0, 0, 0, 0));
    rows.push_back(mk_row(1, 1, 1, 24'h055555, 24'hAAAAAA, 0, 0, 0, 0));
    rows.push_back(mk_row(512, 256, 768, 24'h100000, -24'sd4096, 0, 0, 0, 0));
    foreach (rows[k]) begin
      send_mode(rows[k].m, 1'b1);
      if (rows[k].known) begin
        got = pending_powers[$];
        if (got !== rows[k].p) begin
          mismatches++;
          if (mismatches <= 10) $display("Directed row %0d: predictor disagrees", k);
        end
      end
    end
    start <= 1'b0;
    drain();

    // Tiny sizes, where nonzero modes can have all-zero momentum.
    write_reg(vhsp_pkg::REG_SIZE_X, 11'd0);
    write_reg(vhsp_pkg::REG_SIZE_Y, 11'd1);
    write_reg(vhsp_pkg::REG_SIZE_Z, 11'd2);
    write_reg(vhsp_pkg::REG_X_OFFSET, 11'd1023);
    random_phase(60);
    drain();

    // Largest sizes, including bits above the clamp.
    write_reg(vhsp_pkg::REG_SIZE_X, 11'd2047);
    write_reg(vhsp_pkg::REG_SIZE_Y, 11'd1024);
    write_reg(vhsp_pkg::REG_SIZE_Z, 11'd1025);
    write_reg(vhsp_pkg::REG_X_OFFSET, 11'h7FF);
    random_phase(120);
    drain();

    // Odd and random sizes.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(vhsp_pkg::REG_SIZE_X, 11'($urandom_range(2, 1024)));
      write_reg(vhsp_pkg::REG_SIZE_Y, 11'($urandom_range(2, 1024)));
      write_reg(vhsp_pkg::REG_SIZE_Z, 11'($urandom_range(2, 40)));
      write_reg(vhsp_pkg::REG_X_OFFSET, 11'($urandom));
      random_phase(100);
      drain();
    end

    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/vhsp_pkg.sv
src/vhsp_sine.sv
src/vector_helmholtz_split_power_core.sv
tb/tb_vector_helmholtz_split_power_core.sv
